@@ sv/imufd_pkg.sv @@
// Shared types and constants of the IMU CAN frame decoder.
package imufd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int BYTE_W = 8;
	localparam int ID_W = 8;
	localparam int CODE_W = 16;
	localparam int QCODE_W = 14;
	localparam int CODE_MAX = (1 << CODE_W) - 1;
	localparam int QCODE_MAX = (1 << QCODE_W) - 1;
	localparam int SH_LONG = FRAC_BITS + 1 - CODE_W;
	localparam int SH_QUAT = FRAC_BITS + 1 - QCODE_W;

	localparam int VAL_W = 25;
	localparam int VALD_W = 18;
	localparam int TC_W = 16;
	localparam int YAW_W = 41;
	localparam int KIND_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_W = 10;
	localparam int NUM_ACCEL = 294;
	localparam int NUM_GYRO = 872;
	localparam int NUM_PITCH = 90;
	localparam int NUM_ANGLE = 180;
	localparam int NUM_QUAT = 1;
	localparam int DEN_ACCEL = 5;
	localparam int DEN_GYRO = 25;

	localparam int SUM_W = CODE_W + 1;
	localparam int P_W = NUM_W + CODE_W;
	localparam int Y_W = P_W + SH_LONG;
	localparam int A_W = Y_W - QCODE_W;
	localparam int X_W = Y_W + 1;
	localparam int H_W = X_W - 1;

	localparam int RECIP_SHIFT = 32;
	localparam longint RECIP_ACCEL =
		((longint'(1) << RECIP_SHIFT) + DEN_ACCEL - 1) / DEN_ACCEL;
	localparam longint RECIP_GYRO =
		((longint'(1) << RECIP_SHIFT) + DEN_GYRO - 1) / DEN_GYRO;
	localparam int RC_W = $clog2(RECIP_ACCEL + 1);
	localparam int PQ_W = H_W + RC_W;

	localparam longint HALF_TURN = longint'(180) << FRAC_BITS;
	localparam longint YAW_UNIT = longint'(360) << FRAC_BITS;
	localparam longint YAW_LIM = (longint'(1) << (YAW_W - 1)) - 1;
	localparam longint YAW_TMAX = YAW_LIM / YAW_UNIT + 1;

	localparam logic [ID_W-1:0] ACCEL_ID_RST = 8'd1;
	localparam logic [ID_W-1:0] GYRO_ID_RST = 8'd2;
	localparam logic [ID_W-1:0] EULER_ID_RST = 8'd3;
	localparam logic [ID_W-1:0] QUAT_ID_RST = 8'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEL = 3'd0,
		KIND_GYRO = 3'd1,
		KIND_EULER = 3'd2,
		KIND_QUAT = 3'd3,
		KIND_UNKNOWN = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEL_ID = 2'd0,
		CFG_GYRO_ID = 2'd1,
		CFG_EULER_ID = 2'd2,
		CFG_QUAT_ID = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIV_ONE = 2'd0,
		DIV_ACCEL = 2'd1,
		DIV_GYRO = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic zero;
		logic quat;
		logic [NUM_W-1:0] num;
		div_sel_t div;
	} lane_cfg_t;

endpackage

@@ sv/imufd_lane.sv @@
// One scaling lane: maps a raw code onto its range in signed fixed point, rounded to nearest.
module imufd_lane (
	input logic clk,
	input logic en_s2,
	input logic en_s3,
	input logic [imufd_pkg::CODE_W-1:0] code,
	input imufd_pkg::lane_cfg_t cfg,
	output logic signed [imufd_pkg::VAL_W-1:0] value_s3
);

	logic [imufd_pkg::SUM_W-1:0] m;
	logic [imufd_pkg::SUM_W-1:0] two;
	logic neg;
	logic [imufd_pkg::SUM_W-1:0] mag;
	logic [imufd_pkg::P_W-1:0] prod_p;
	logic [imufd_pkg::Y_W-1:0] y;
	logic [imufd_pkg::A_W-1:0] a;
	logic [imufd_pkg::CODE_W-1:0] b;
	logic [imufd_pkg::SUM_W-1:0] s;
	logic corr;
	logic [imufd_pkg::X_W-1:0] dv;
	logic [imufd_pkg::X_W-1:0] x1;

	logic [imufd_pkg::H_W-1:0] h_s2;
	logic neg_s2;
	logic zero_s2;
	imufd_pkg::div_sel_t div_s2;

	logic [imufd_pkg::RC_W-1:0] rc;
	logic [imufd_pkg::PQ_W-1:0] prod_q;
	logic [imufd_pkg::VAL_W-1:0] q;
	logic [imufd_pkg::VAL_W-1:0] res;

	// Division by 2^bits - 1 folds into the code word itself plus a one-step correction.
	always_comb begin
		m = cfg.quat ? imufd_pkg::SUM_W'(imufd_pkg::QCODE_MAX) :
			imufd_pkg::SUM_W'(imufd_pkg::CODE_MAX);
		two = {code, 1'b0};
		neg = two < m;
		mag = neg ? (m - two) : (two - m);
		prod_p = imufd_pkg::P_W'(cfg.num) * imufd_pkg::P_W'(mag[imufd_pkg::CODE_W-1:0]);
		y = cfg.quat ? (imufd_pkg::Y_W'(prod_p) << imufd_pkg::SH_QUAT) :
			(imufd_pkg::Y_W'(prod_p) << imufd_pkg::SH_LONG);
		a = cfg.quat ? y[imufd_pkg::Y_W-1:imufd_pkg::QCODE_W] :
			imufd_pkg::A_W'(y[imufd_pkg::Y_W-1:imufd_pkg::CODE_W]);
		b = cfg.quat ? imufd_pkg::CODE_W'(y[imufd_pkg::QCODE_W-1:0]) :
			y[imufd_pkg::CODE_W-1:0];
		s = imufd_pkg::SUM_W'(a) + imufd_pkg::SUM_W'(b);
		corr = s >= m;
		case (cfg.div)
			imufd_pkg::DIV_ACCEL: dv = imufd_pkg::X_W'(imufd_pkg::DEN_ACCEL);
			imufd_pkg::DIV_GYRO: dv = imufd_pkg::X_W'(imufd_pkg::DEN_GYRO);
			default: dv = imufd_pkg::X_W'(1);
		endcase
		x1 = imufd_pkg::X_W'(y) + imufd_pkg::X_W'(a) + imufd_pkg::X_W'(corr) + dv;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			h_s2 <= x1[imufd_pkg::X_W-1:1];
			neg_s2 <= neg;
			zero_s2 <= cfg.zero;
			div_s2 <= cfg.div;
		end
	end

	// The remaining division by the range denominator is a reciprocal multiplication.
	always_comb begin
		case (div_s2)
			imufd_pkg::DIV_ACCEL: rc = imufd_pkg::RC_W'(imufd_pkg::RECIP_ACCEL);
			imufd_pkg::DIV_GYRO: rc = imufd_pkg::RC_W'(imufd_pkg::RECIP_GYRO);
			default: rc = '0;
		endcase
		prod_q = imufd_pkg::PQ_W'(h_s2) * imufd_pkg::PQ_W'(rc);
		q = (div_s2 == imufd_pkg::DIV_ONE) ? imufd_pkg::VAL_W'(h_s2) :
			prod_q[imufd_pkg::RECIP_SHIFT +: imufd_pkg::VAL_W];
		res = zero_s2 ? '0 : (neg_s2 ? -q : q);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			value_s3 <= res;
		end
	end

endmodule

@@ sv/imufd_unwrap.sv @@
// Yaw unwrap state: the saturating turn counter and the latest Euler yaw.
module imufd_unwrap #(
	parameter int TURN_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic upd,
	input logic signed [imufd_pkg::VAL_W-1:0] yaw,
	output logic signed [TURN_BITS-1:0] turns_q,
	output logic signed [imufd_pkg::VAL_W-1:0] last_yaw_q
);

	localparam int D_W = imufd_pkg::VAL_W + 1;
	localparam logic signed [D_W-1:0] HALF = D_W'(imufd_pkg::HALF_TURN);
	localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS - 1){1'b0}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS - 1){1'b1}}};

	logic signed [D_W-1:0] diff;

	assign diff = D_W'(yaw) - D_W'(last_yaw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turns_q <= '0;
			last_yaw_q <= '0;
		end else if (upd) begin
			if (diff > HALF) begin
				if (turns_q != TURN_MIN) begin
					turns_q <= turns_q - TURN_BITS'(1);
				end
			end else if (diff < -HALF) begin
				if (turns_q != TURN_MAX) begin
					turns_q <= turns_q + TURN_BITS'(1);
				end
			end
			last_yaw_q <= yaw;
		end
	end

endmodule

@@ sv/imu_can_frame_decoder_core.sv @@
// Top level of the IMU CAN frame decoder: frame pipeline, kind registers and yaw total.
// Pipeline: five register stages. Throughput: one frame per cycle while the output accepts;
// each stage advances whenever the stage after it has room, so bubbles are absorbed and input
// transfers continue while a result waits at the output, until the earlier stages are full.
// Reset: the kind registers return to 1, 2, 3 and 4, the turn counter and last yaw clear to
// zero, and the pipeline empties.
module imu_can_frame_decoder_core #(
	parameter int TURN_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [imufd_pkg::BYTE_W-1:0] byte0,
	input logic [imufd_pkg::BYTE_W-1:0] byte1,
	input logic [imufd_pkg::BYTE_W-1:0] byte2,
	input logic [imufd_pkg::BYTE_W-1:0] byte3,
	input logic [imufd_pkg::BYTE_W-1:0] byte4,
	input logic [imufd_pkg::BYTE_W-1:0] byte5,
	input logic [imufd_pkg::BYTE_W-1:0] byte6,
	input logic [imufd_pkg::BYTE_W-1:0] byte7,
	output logic out_valid,
	input logic out_ready,
	output logic [imufd_pkg::KIND_W-1:0] frame_type,
	output logic signed [imufd_pkg::VAL_W-1:0] value_a,
	output logic signed [imufd_pkg::VAL_W-1:0] value_b,
	output logic signed [imufd_pkg::VAL_W-1:0] value_c,
	output logic signed [imufd_pkg::VALD_W-1:0] value_d,
	output logic signed [imufd_pkg::TC_W-1:0] turn_count,
	output logic signed [imufd_pkg::YAW_W-1:0] yaw_total,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [imufd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [imufd_pkg::ID_W-1:0] cfg_data
);

	localparam int TLO_W = $clog2(imufd_pkg::YAW_TMAX + 1) + 1;
	localparam int TEXT_W = (TURN_BITS > TLO_W) ? TURN_BITS : TLO_W;
	localparam int UNIT_W = $clog2(imufd_pkg::YAW_UNIT + 1) + 1;
	localparam int PR_W = TLO_W + UNIT_W;

	function automatic imufd_pkg::lane_cfg_t lane_cfg(input imufd_pkg::kind_t kind,
			input logic pitch, input logic z_lane);
		imufd_pkg::lane_cfg_t c;
		c.zero = 1'b0;
		c.quat = 1'b0;
		c.num = imufd_pkg::NUM_W'(imufd_pkg::NUM_ANGLE);
		c.div = imufd_pkg::DIV_ONE;
		case (kind)
			imufd_pkg::KIND_ACCEL: begin
				c.num = imufd_pkg::NUM_W'(imufd_pkg::NUM_ACCEL);
				c.div = imufd_pkg::DIV_ACCEL;
				c.zero = z_lane;
			end
			imufd_pkg::KIND_GYRO: begin
				c.num = imufd_pkg::NUM_W'(imufd_pkg::NUM_GYRO);
				c.div = imufd_pkg::DIV_GYRO;
				c.zero = z_lane;
			end
			imufd_pkg::KIND_EULER: begin
				c.num = pitch ? imufd_pkg::NUM_W'(imufd_pkg::NUM_PITCH) :
					imufd_pkg::NUM_W'(imufd_pkg::NUM_ANGLE);
				c.zero = z_lane;
			end
			imufd_pkg::KIND_QUAT: begin
				c.num = imufd_pkg::NUM_W'(imufd_pkg::NUM_QUAT);
				c.quat = 1'b1;
			end
			default: c.zero = 1'b1;
		endcase
		return c;
	endfunction

	logic [imufd_pkg::ID_W-1:0] accel_id_q;
	logic [imufd_pkg::ID_W-1:0] gyro_id_q;
	logic [imufd_pkg::ID_W-1:0] euler_id_q;
	logic [imufd_pkg::ID_W-1:0] quat_id_q;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic rdy4;
	logic rdy5;
	logic en1;
	logic en2;
	logic en3;
	logic en4;
	logic en5;

	logic [7:0][imufd_pkg::BYTE_W-1:0] frame_s1;
	imufd_pkg::kind_t kind_d;
	imufd_pkg::kind_t kind_s2;
	imufd_pkg::kind_t kind_s3;
	imufd_pkg::kind_t kind_s4;
	imufd_pkg::kind_t kind_s5;

	logic [imufd_pkg::CODE_W-1:0] code_a;
	logic [imufd_pkg::CODE_W-1:0] code_b;
	logic [imufd_pkg::CODE_W-1:0] code_c;
	logic [imufd_pkg::CODE_W-1:0] code_d;
	imufd_pkg::lane_cfg_t cfg_a;
	imufd_pkg::lane_cfg_t cfg_b;
	imufd_pkg::lane_cfg_t cfg_c;
	imufd_pkg::lane_cfg_t cfg_d;

	logic signed [imufd_pkg::VAL_W-1:0] va_s3;
	logic signed [imufd_pkg::VAL_W-1:0] vb_s3;
	logic signed [imufd_pkg::VAL_W-1:0] vc_s3;
	logic signed [imufd_pkg::VAL_W-1:0] vd_s3;
	logic signed [imufd_pkg::VAL_W-1:0] va_s4;
	logic signed [imufd_pkg::VAL_W-1:0] vb_s4;
	logic signed [imufd_pkg::VAL_W-1:0] vc_s4;
	logic signed [imufd_pkg::VAL_W-1:0] vd_s4;
	logic signed [imufd_pkg::VAL_W-1:0] va_s5;
	logic signed [imufd_pkg::VAL_W-1:0] vb_s5;
	logic signed [imufd_pkg::VAL_W-1:0] vc_s5;
	logic signed [imufd_pkg::VALD_W-1:0] vd_s5;
	logic signed [imufd_pkg::TC_W-1:0] tc_s5;
	logic signed [imufd_pkg::YAW_W-1:0] yaw_s5;

	logic signed [TURN_BITS-1:0] turns_q;
	logic signed [imufd_pkg::VAL_W-1:0] last_yaw_q;
	logic signed [TEXT_W-1:0] t_ext;
	logic signed [TLO_W-1:0] t_lo;
	logic signed [PR_W-1:0] yaw_sum;
	logic signed [imufd_pkg::YAW_W-1:0] yaw_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_id_q <= imufd_pkg::ACCEL_ID_RST;
			gyro_id_q <= imufd_pkg::GYRO_ID_RST;
			euler_id_q <= imufd_pkg::EULER_ID_RST;
			quat_id_q <= imufd_pkg::QUAT_ID_RST;
		end else if (cfg_valid) begin
			case (imufd_pkg::cfg_reg_t'(cfg_index))
				imufd_pkg::CFG_ACCEL_ID: accel_id_q <= cfg_data;
				imufd_pkg::CFG_GYRO_ID: gyro_id_q <= cfg_data;
				imufd_pkg::CFG_EULER_ID: euler_id_q <= cfg_data;
				imufd_pkg::CFG_QUAT_ID: quat_id_q <= cfg_data;
				default: quat_id_q <= quat_id_q;
			endcase
		end
	end

	assign rdy5 = !valid_s5 || out_ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	assign en1 = in_valid && rdy1;
	assign en2 = valid_s1 && rdy2;
	assign en3 = valid_s2 && rdy3;
	assign en4 = valid_s3 && rdy4;
	assign en5 = valid_s4 && rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			frame_s1 <= {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
		end
	end

	// The first matching register wins, in the order accelerometer, gyro, Euler, quaternion.
	always_comb begin
		if (frame_s1[0] == accel_id_q) begin
			kind_d = imufd_pkg::KIND_ACCEL;
		end else if (frame_s1[0] == gyro_id_q) begin
			kind_d = imufd_pkg::KIND_GYRO;
		end else if (frame_s1[0] == euler_id_q) begin
			kind_d = imufd_pkg::KIND_EULER;
		end else if (frame_s1[0] == quat_id_q) begin
			kind_d = imufd_pkg::KIND_QUAT;
		end else begin
			kind_d = imufd_pkg::KIND_UNKNOWN;
		end
	end

	always_comb begin
		if (kind_d == imufd_pkg::KIND_QUAT) begin
			code_a = imufd_pkg::CODE_W'({frame_s1[1], frame_s1[2][7:2]});
			code_b = imufd_pkg::CODE_W'({frame_s1[2][1:0], frame_s1[3], frame_s1[4][7:4]});
			code_c = imufd_pkg::CODE_W'({frame_s1[4][3:0], frame_s1[5], frame_s1[6][7:6]});
		end else begin
			code_a = {frame_s1[3], frame_s1[2]};
			code_b = {frame_s1[5], frame_s1[4]};
			code_c = {frame_s1[7], frame_s1[6]};
		end
		code_d = imufd_pkg::CODE_W'({frame_s1[6][5:0], frame_s1[7]});
		cfg_a = lane_cfg(kind_d, 1'b1, 1'b0);
		cfg_b = lane_cfg(kind_d, 1'b0, 1'b0);
		cfg_c = lane_cfg(kind_d, 1'b0, 1'b0);
		cfg_d = lane_cfg(kind_d, 1'b0, 1'b1);
	end

	imufd_lane u_lane_a (
		.clk(clk),
		.en_s2(en2),
		.en_s3(en3),
		.code(code_a),
		.cfg(cfg_a),
		.value_s3(va_s3)
	);

	imufd_lane u_lane_b (
		.clk(clk),
		.en_s2(en2),
		.en_s3(en3),
		.code(code_b),
		.cfg(cfg_b),
		.value_s3(vb_s3)
	);

	imufd_lane u_lane_c (
		.clk(clk),
		.en_s2(en2),
		.en_s3(en3),
		.code(code_c),
		.cfg(cfg_c),
		.value_s3(vc_s3)
	);

	imufd_lane u_lane_d (
		.clk(clk),
		.en_s2(en2),
		.en_s3(en3),
		.code(code_d),
		.cfg(cfg_d),
		.value_s3(vd_s3)
	);

	imufd_unwrap #(
		.TURN_BITS(TURN_BITS)
	) u_unwrap (
		.clk(clk),
		.arst_n(arst_n),
		.upd(en4 && (kind_s3 == imufd_pkg::KIND_EULER)),
		.yaw(vb_s3),
		.turns_q(turns_q),
		.last_yaw_q(last_yaw_q)
	);

	// The counter state always matches the frame held in stage four, so stage five reads it directly.
	always_comb begin
		t_ext = TEXT_W'(turns_q);
		t_lo = t_ext[TLO_W-1:0];
		yaw_sum = PR_W'(t_lo) * PR_W'(imufd_pkg::YAW_UNIT) + PR_W'(last_yaw_q);
		if (t_ext > TEXT_W'(imufd_pkg::YAW_TMAX)) begin
			yaw_d = imufd_pkg::YAW_W'(imufd_pkg::YAW_LIM);
		end else if (t_ext < -TEXT_W'(imufd_pkg::YAW_TMAX)) begin
			yaw_d = imufd_pkg::YAW_W'(-imufd_pkg::YAW_LIM - 1);
		end else if (yaw_sum > PR_W'(imufd_pkg::YAW_LIM)) begin
			yaw_d = imufd_pkg::YAW_W'(imufd_pkg::YAW_LIM);
		end else if (yaw_sum < PR_W'(-imufd_pkg::YAW_LIM - 1)) begin
			yaw_d = imufd_pkg::YAW_W'(-imufd_pkg::YAW_LIM - 1);
		end else begin
			yaw_d = yaw_sum[imufd_pkg::YAW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2 <= kind_d;
		end
		if (en3) begin
			kind_s3 <= kind_s2;
		end
		if (en4) begin
			kind_s4 <= kind_s3;
			va_s4 <= va_s3;
			vb_s4 <= vb_s3;
			vc_s4 <= vc_s3;
			vd_s4 <= vd_s3;
		end
		if (en5) begin
			kind_s5 <= kind_s4;
			va_s5 <= va_s4;
			vb_s5 <= vb_s4;
			vc_s5 <= vc_s4;
			vd_s5 <= vd_s4[imufd_pkg::VALD_W-1:0];
			tc_s5 <= t_ext[imufd_pkg::TC_W-1:0];
			yaw_s5 <= yaw_d;
		end
	end

	assign out_valid = valid_s5;
	assign frame_type = kind_s5;
	assign value_a = va_s5;
	assign value_b = vb_s5;
	assign value_c = vc_s5;
	assign value_d = vd_s5;
	assign turn_count = tc_s5;
	assign yaw_total = yaw_s5;

endmodule

@@ verif/imufd_checker.sv @@
`timescale 1ns / 1ps
// Checker for the IMU CAN frame decoder: predicts every frame's result and compares it at the output.
module imufd_checker #(
	parameter int TURN_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [imufd_pkg::BYTE_W-1:0] byte0,
	input logic [imufd_pkg::BYTE_W-1:0] byte1,
	input logic [imufd_pkg::BYTE_W-1:0] byte2,
	input logic [imufd_pkg::BYTE_W-1:0] byte3,
	input logic [imufd_pkg::BYTE_W-1:0] byte4,
	input logic [imufd_pkg::BYTE_W-1:0] byte5,
	input logic [imufd_pkg::BYTE_W-1:0] byte6,
	input logic [imufd_pkg::BYTE_W-1:0] byte7,
	input logic out_valid,
	input logic out_ready,
	input logic [imufd_pkg::KIND_W-1:0] frame_type,
	input logic signed [imufd_pkg::VAL_W-1:0] value_a,
	input logic signed [imufd_pkg::VAL_W-1:0] value_b,
	input logic signed [imufd_pkg::VAL_W-1:0] value_c,
	input logic signed [imufd_pkg::VALD_W-1:0] value_d,
	input logic signed [imufd_pkg::TC_W-1:0] turn_count,
	input logic signed [imufd_pkg::YAW_W-1:0] yaw_total,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [imufd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [imufd_pkg::ID_W-1:0] cfg_data,
	output int errors,
	output int outstanding
);

	typedef struct {
		imufd_pkg::kind_t kind;
		logic signed [imufd_pkg::VAL_W-1:0] a;
		logic signed [imufd_pkg::VAL_W-1:0] b;
		logic signed [imufd_pkg::VAL_W-1:0] c;
		logic signed [imufd_pkg::VALD_W-1:0] d;
		logic signed [imufd_pkg::TC_W-1:0] turns;
		logic signed [imufd_pkg::YAW_W-1:0] yaw;
	} decoded_t;

	localparam longint TURN_MAX = (longint'(1) << (TURN_BITS - 1)) - 1;
	localparam longint TURN_MIN = -TURN_MAX - 1;

	logic [imufd_pkg::ID_W-1:0] kind_id [4];
	longint heading;
	longint turn_ctr;
	decoded_t expected_q [$];
	int err_count = 0;
	int pending_n = 0;

	assign errors = err_count;
	assign outstanding = pending_n;

	// Linear map of a code onto [-R, +R] with R = num / den, rounded half away from zero.
	function automatic longint map_code(input longint unsigned code, input int bits,
			input longint unsigned num, input longint unsigned den);
		longint unsigned span;
		longint unsigned mag;
		longint unsigned n;
		longint unsigned d;
		longint unsigned q;
		longint t;
		span = (longint'(1) << bits) - 1;
		t = 2 * longint'(code) - longint'(span);
		mag = (t < 0) ? -t : t;
		n = (num * mag) << imufd_pkg::FRAC_BITS;
		d = den * span;
		q = (2 * n + d) / (2 * d);
		return (t < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic decoded_t decode_frame(input logic [7:0][imufd_pkg::BYTE_W-1:0] b);
		decoded_t r;
		logic [imufd_pkg::CODE_W-1:0] c0;
		logic [imufd_pkg::CODE_W-1:0] c1;
		logic [imufd_pkg::CODE_W-1:0] c2;
		logic [imufd_pkg::QCODE_W-1:0] qw;
		logic [imufd_pkg::QCODE_W-1:0] qx;
		logic [imufd_pkg::QCODE_W-1:0] qy;
		logic [imufd_pkg::QCODE_W-1:0] qz;
		longint va;
		longint vb;
		longint vc;
		longint vd;
		longint diff;
		longint yaw_v;
		va = 0;
		vb = 0;
		vc = 0;
		vd = 0;
		c0 = {b[3], b[2]};
		c1 = {b[5], b[4]};
		c2 = {b[7], b[6]};
		qw = {b[1], b[2][7:2]};
		qx = {b[2][1:0], b[3], b[4][7:4]};
		qy = {b[4][3:0], b[5], b[6][7:6]};
		qz = {b[6][5:0], b[7]};
		if (b[0] == kind_id[imufd_pkg::CFG_ACCEL_ID]) r.kind = imufd_pkg::KIND_ACCEL;
		else if (b[0] == kind_id[imufd_pkg::CFG_GYRO_ID]) r.kind = imufd_pkg::KIND_GYRO;
		else if (b[0] == kind_id[imufd_pkg::CFG_EULER_ID]) r.kind = imufd_pkg::KIND_EULER;
		else if (b[0] == kind_id[imufd_pkg::CFG_QUAT_ID]) r.kind = imufd_pkg::KIND_QUAT;
		else r.kind = imufd_pkg::KIND_UNKNOWN;
		case (r.kind)
			imufd_pkg::KIND_ACCEL: begin
				va = map_code(c0, imufd_pkg::CODE_W, imufd_pkg::NUM_ACCEL,
					imufd_pkg::DEN_ACCEL);
				vb = map_code(c1, imufd_pkg::CODE_W, imufd_pkg::NUM_ACCEL,
					imufd_pkg::DEN_ACCEL);
				vc = map_code(c2, imufd_pkg::CODE_W, imufd_pkg::NUM_ACCEL,
					imufd_pkg::DEN_ACCEL);
			end
			imufd_pkg::KIND_GYRO: begin
				va = map_code(c0, imufd_pkg::CODE_W, imufd_pkg::NUM_GYRO,
					imufd_pkg::DEN_GYRO);
				vb = map_code(c1, imufd_pkg::CODE_W, imufd_pkg::NUM_GYRO,
					imufd_pkg::DEN_GYRO);
				vc = map_code(c2, imufd_pkg::CODE_W, imufd_pkg::NUM_GYRO,
					imufd_pkg::DEN_GYRO);
			end
			imufd_pkg::KIND_EULER: begin
				va = map_code(c0, imufd_pkg::CODE_W, imufd_pkg::NUM_PITCH, 1);
				vb = map_code(c1, imufd_pkg::CODE_W, imufd_pkg::NUM_ANGLE, 1);
				vc = map_code(c2, imufd_pkg::CODE_W, imufd_pkg::NUM_ANGLE, 1);
				// A jump of more than half a turn is taken as a wrap, and the counter saturates.
				diff = vb - heading;
				if (diff > imufd_pkg::HALF_TURN) begin
					if (turn_ctr > TURN_MIN) turn_ctr--;
				end else if (diff < -imufd_pkg::HALF_TURN) begin
					if (turn_ctr < TURN_MAX) turn_ctr++;
				end
				heading = vb;
			end
			imufd_pkg::KIND_QUAT: begin
				va = map_code(qw, imufd_pkg::QCODE_W, imufd_pkg::NUM_QUAT, 1);
				vb = map_code(qx, imufd_pkg::QCODE_W, imufd_pkg::NUM_QUAT, 1);
				vc = map_code(qy, imufd_pkg::QCODE_W, imufd_pkg::NUM_QUAT, 1);
				vd = map_code(qz, imufd_pkg::QCODE_W, imufd_pkg::NUM_QUAT, 1);
			end
			default: ;
		endcase
		yaw_v = turn_ctr * imufd_pkg::YAW_UNIT + heading;
		r.a = va[imufd_pkg::VAL_W-1:0];
		r.b = vb[imufd_pkg::VAL_W-1:0];
		r.c = vc[imufd_pkg::VAL_W-1:0];
		r.d = vd[imufd_pkg::VALD_W-1:0];
		r.turns = turn_ctr[imufd_pkg::TC_W-1:0];
		r.yaw = yaw_v[imufd_pkg::YAW_W-1:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input longint exp_v,
			input longint act_v);
		if (exp_v != act_v) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		decoded_t exp_r;
		if (!arst_n) begin
			kind_id[imufd_pkg::CFG_ACCEL_ID] = imufd_pkg::ACCEL_ID_RST;
			kind_id[imufd_pkg::CFG_GYRO_ID] = imufd_pkg::GYRO_ID_RST;
			kind_id[imufd_pkg::CFG_EULER_ID] = imufd_pkg::EULER_ID_RST;
			kind_id[imufd_pkg::CFG_QUAT_ID] = imufd_pkg::QUAT_ID_RST;
			heading = 0;
			turn_ctr = 0;
			expected_q.delete();
			pending_n <= 0;
		end else begin
			if (cfg_valid && cfg_ready) kind_id[cfg_index] = cfg_data;
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					err_count++;
					$display("%0t: result transfer with no frame outstanding", $time);
				end else begin
					exp_r = expected_q.pop_front();
					check_field("frame_type", exp_r.kind, frame_type);
					check_field("value_a", exp_r.a, value_a);
					check_field("value_b", exp_r.b, value_b);
					check_field("value_c", exp_r.c, value_c);
					check_field("value_d", exp_r.d, value_d);
					check_field("turn_count", exp_r.turns, turn_count);
					check_field("yaw_total", exp_r.yaw, yaw_total);
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(decode_frame({byte7, byte6, byte5, byte4,
					byte3, byte2, byte1, byte0}));
			pending_n <= expected_q.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the IMU CAN frame decoder: clock, reset, stimulus, flow control and verdict.
module tb_top;

	localparam int HOLD_CYCLES = 300;
	localparam logic [15:0] YAW_NEG = 16'h38E3;
	localparam logic [15:0] YAW_MID = 16'h8000;
	localparam logic [15:0] YAW_POS = 16'hC71C;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [imufd_pkg::BYTE_W-1:0] byte0 = '0;
	logic [imufd_pkg::BYTE_W-1:0] byte1 = '0;
	logic [imufd_pkg::BYTE_W-1:0] byte2 = '0;
	logic [imufd_pkg::BYTE_W-1:0] byte3 = '0;
	logic [imufd_pkg::BYTE_W-1:0] byte4 = '0;
	logic [imufd_pkg::BYTE_W-1:0] byte5 = '0;
	logic [imufd_pkg::BYTE_W-1:0] byte6 = '0;
	logic [imufd_pkg::BYTE_W-1:0] byte7 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [imufd_pkg::KIND_W-1:0] frame_type;
	logic signed [imufd_pkg::VAL_W-1:0] value_a;
	logic signed [imufd_pkg::VAL_W-1:0] value_b;
	logic signed [imufd_pkg::VAL_W-1:0] value_c;
	logic signed [imufd_pkg::VALD_W-1:0] value_d;
	logic signed [imufd_pkg::TC_W-1:0] turn_count;
	logic signed [imufd_pkg::YAW_W-1:0] yaw_total;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [imufd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [imufd_pkg::ID_W-1:0] cfg_data = '0;
	int errors;
	int outstanding;

	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	logic [imufd_pkg::ID_W-1:0] kind_ids [4];

	always #4 clk = ~clk;

	imu_can_frame_decoder_core i_dut (.*);

	imufd_checker i_checker (.*);

	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// The receiver runs on its own, with an occasional long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_frame(input logic [7:0] k, input logic [7:0] p1,
			input logic [7:0] p2, input logic [7:0] p3, input logic [7:0] p4,
			input logic [7:0] p5, input logic [7:0] p6, input logic [7:0] p7);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte0 <= k;
		byte1 <= p1;
		byte2 <= p2;
		byte3 <= p3;
		byte4 <= p4;
		byte5 <= p5;
		byte6 <= p6;
		byte7 <= p7;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_id(input imufd_pkg::cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		kind_ids[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [7:0] a, input logic [7:0] g,
			input logic [7:0] e, input logic [7:0] q);
		drain();
		write_id(imufd_pkg::CFG_ACCEL_ID, a);
		write_id(imufd_pkg::CFG_GYRO_ID, g);
		write_id(imufd_pkg::CFG_EULER_ID, e);
		write_id(imufd_pkg::CFG_QUAT_ID, q);
	endtask

	task automatic send_random(input int n);
		logic [7:0] k;
		repeat (n) begin
			if ($urandom_range(9) < 8) k = kind_ids[$urandom_range(3)];
			else k = 8'($urandom);
			send_frame(k, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
				rand_byte(), rand_byte(), rand_byte());
		end
	endtask

	// Three Euler frames per full turn: one jump of 200 degrees, then two steps of 100 back.
	task automatic turn_sweep(input int n, input bit downwards);
		logic [15:0] yaw_seq [3];
		if (downwards) yaw_seq = '{YAW_POS, YAW_MID, YAW_NEG};
		else yaw_seq = '{YAW_NEG, YAW_MID, YAW_POS};
		repeat (n) begin
			for (int j = 0; j < 3; j++)
				send_frame(kind_ids[imufd_pkg::CFG_EULER_ID], rand_byte(), rand_byte(),
					rand_byte(), yaw_seq[j][7:0], yaw_seq[j][15:8], rand_byte(),
					rand_byte());
		end
	endtask

	initial begin
		kind_ids[imufd_pkg::CFG_ACCEL_ID] = imufd_pkg::ACCEL_ID_RST;
		kind_ids[imufd_pkg::CFG_GYRO_ID] = imufd_pkg::GYRO_ID_RST;
		kind_ids[imufd_pkg::CFG_EULER_ID] = imufd_pkg::EULER_ID_RST;
		kind_ids[imufd_pkg::CFG_QUAT_ID] = imufd_pkg::QUAT_ID_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_frame(imufd_pkg::ACCEL_ID_RST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_frame(imufd_pkg::ACCEL_ID_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_frame(imufd_pkg::ACCEL_ID_RST, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h55, 8'hAA);
		send_frame(imufd_pkg::GYRO_ID_RST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_frame(imufd_pkg::GYRO_ID_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_frame(imufd_pkg::GYRO_ID_RST, 8'h5A, 8'h01, 8'h00, 8'hFE, 8'hFF, 8'h80, 8'h7F);
		send_frame(imufd_pkg::EULER_ID_RST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
		send_frame(imufd_pkg::EULER_ID_RST, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
		send_frame(imufd_pkg::EULER_ID_RST, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h80);
		send_frame(imufd_pkg::EULER_ID_RST, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h7F);
		send_frame(imufd_pkg::QUAT_ID_RST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_frame(imufd_pkg::QUAT_ID_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_frame(imufd_pkg::QUAT_ID_RST, 8'h00, 8'hFC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_frame(imufd_pkg::QUAT_ID_RST, 8'h00, 8'h03, 8'hFF, 8'hF0, 8'h0F, 8'hFF, 8'hC0);
		send_frame(imufd_pkg::QUAT_ID_RST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3F, 8'hFF);
		send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_frame(8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE);

		write_all(8'd7, 8'd7, 8'd7, 8'd7);
		send_frame(8'd7, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE);
		write_all(8'd8, 8'd9, 8'd9, 8'd9);
		send_frame(8'd9, 8'hDE, 8'hBC, 8'h9A, 8'h78, 8'h56, 8'h34, 8'h12);
		write_all(8'd0, 8'd1, 8'd255, 8'd255);
		send_frame(8'd255, 8'h80, 8'h00, 8'h40, 8'h00, 8'hC0, 8'h00, 8'h20);
		send_frame(8'd0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07);
		write_all(8'd255, 8'd254, 8'd253, 8'd0);
		send_frame(8'd0, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h96, 8'h69, 8'hF0);
		send_frame(8'd253, 8'h0F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);

		// Walk the turn counter down through several wraps and then back up past zero.
		write_all(imufd_pkg::ACCEL_ID_RST, imufd_pkg::GYRO_ID_RST, imufd_pkg::EULER_ID_RST,
			imufd_pkg::QUAT_ID_RST);
		turn_sweep(10, 1'b1);
		turn_sweep(20, 1'b0);

		drain();
		send_random(200);
		hold_req = 1'b1;
		send_random(250);

		write_all(8'd0, 8'd255, 8'd128, 8'd127);
		idle_pct = 85;
		send_random(225);
		drain();
		send_random(225);

		write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		idle_pct = 0;
		stall_pct = 85;
		send_random(450);

		write_all(8'd255, 8'd0, 8'hA5, 8'h5A);
		idle_pct = 21;
		stall_pct = 21;
		send_random(450);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
sv/imufd_pkg.sv
sv/imufd_lane.sv
sv/imufd_unwrap.sv
sv/imu_can_frame_decoder_core.sv
verif/imufd_checker.sv
verif/tb_top.sv
